// ===== design/hostname_pattern_match_assert.svh =====
// assertion macros used by the top-level design file
`ifndef HOSTNAME_PATTERN_MATCH_ASSERT_SVH
`define HOSTNAME_PATTERN_MATCH_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define HPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/hpm_pkg.sv =====
package hpm_pkg;

  // largest pattern the registers can hold
  localparam int PAT_MAX_BYTES = 32;

  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_QUEST   = 8'h3F;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // register indexes on the configuration port
  localparam logic [2:0] REG_PATTERN_WORD_0 = 3'd0;
  localparam logic [2:0] REG_PATTERN_WORD_3 = 3'd3;
  localparam logic [2:0] REG_PATTERN_LENGTH = 3'd4;
  localparam logic [2:0] REG_IGNORE_CASE    = 3'd5;
  localparam logic [2:0] REG_INVERT_RESULT  = 3'd6;

  typedef enum logic [1:0] {
    CLS_EXACT     = 2'd0,
    CLS_SUBDOMAIN = 2'd1,
    CLS_CONTAINS  = 2'd2,
    CLS_COMPLEX   = 2'd3
  } cls_t;

  // match flags carried from cell to cell
  typedef struct packed {
    logic a;  // pattern prefix ends at the newest byte
    logic d;  // pattern prefix from byte 1 ends at the newest byte
    logic x;  // pattern prefix equals the text from its start
  } chain_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ic);
    logic [7:0] r;
    r = c;
    if (ic && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) r = c + CASE_OFFSET;
    return r;
  endfunction

endpackage

// ===== design/hpm_cell.sv =====
module hpm_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic            clear,
  input  logic            ignore_case,
  input  logic [7:0]      text_byte,   // already folded
  input  logic [7:0]      pat_byte,    // raw pattern byte
  input  hpm_pkg::chain_t prev,
  output hpm_pkg::chain_t flags_nxt,
  output hpm_pkg::chain_t flags_r
);

  logic eq;

  assign eq = (text_byte == hpm_pkg::fold_byte(pat_byte, ignore_case));

  assign flags_nxt.a = prev.a & eq;
  assign flags_nxt.d = prev.d & eq;
  assign flags_nxt.x = prev.x & eq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (step) begin
      flags_r <= clear ? '0 : flags_nxt;
    end
  end

endmodule

// ===== design/hpm_classify.sv =====
module hpm_classify #(
  parameter int NUM_CELLS = 32
) (
  input  logic [NUM_CELLS-1:0][7:0] pat_bytes,
  input  logic [5:0]                len,
  input  logic                      len_ok,
  output hpm_pkg::cls_t             cls
);

  logic dot;
  logic star;
  logic quest;
  logic star_dot;

  always_comb begin
    dot      = 1'b0;
    star     = 1'b0;
    quest    = 1'b0;
    star_dot = 1'b0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (6'(i) < len) begin
        if (pat_bytes[i] == hpm_pkg::CHAR_DOT) dot = 1'b1;
        if (pat_bytes[i] == hpm_pkg::CHAR_QUEST) quest = 1'b1;
        if (pat_bytes[i] == hpm_pkg::CHAR_STAR) begin
          star = 1'b1;
          if ((i + 1 < NUM_CELLS) && (6'(i + 1) < len) &&
              (pat_bytes[(i + 1 < NUM_CELLS) ? i + 1 : i] == hpm_pkg::CHAR_DOT)) begin
            star_dot = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    if (!len_ok) begin
      cls = hpm_pkg::CLS_COMPLEX;
    end else if (dot && !star && !quest) begin
      cls = hpm_pkg::CLS_EXACT;
    end else if (len > 6'd2 && pat_bytes[0] == hpm_pkg::CHAR_STAR &&
                 pat_bytes[1] == hpm_pkg::CHAR_DOT) begin
      cls = hpm_pkg::CLS_SUBDOMAIN;
    end else if (star_dot && pat_bytes[0] != hpm_pkg::CHAR_STAR) begin
      cls = hpm_pkg::CLS_CONTAINS;
    end else if (!dot && !star && !quest) begin
      cls = hpm_pkg::CLS_CONTAINS;
    end else begin
      cls = hpm_pkg::CLS_COMPLEX;
    end
  end

endmodule

// ===== design/hostname_pattern_match.sv =====
// Matches a server name, streamed in one byte per transfer with tlast on the final byte,
// against a configured pattern of up to 32 bytes (fewer if PATTERN_BYTES is smaller).
// The pattern is classed as exact, subdomain ("*." prefix), contains or complex; complex
// never matches. One byte is taken every cycle when not stalled, with no gaps between
// names; each result is registered in the cycle after its name's final byte as the next
// name's bytes flow on. A row of match cells, one per pattern byte, sets the rate: every
// byte is broadcast to all cells and compared in parallel, and each cell passes its
// prefix-match flags to its neighbor, so one byte finishes per cycle. No clearing pass is
// needed after reset. Configuration must be written only while no name is in flight.
module hostname_pattern_match #(
  parameter int PATTERN_BYTES = 32,
  parameter int TEXT_BYTES    = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] text_byte
  input  logic        in_tlast,    // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [0] matched, [1] too_long, [3:2] pattern_class, rest zero
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  `include "hostname_pattern_match_assert.svh"

  // cells beyond 32 could never be reached by a legal pattern length
  localparam int NUM_CELLS = (PATTERN_BYTES < hpm_pkg::PAT_MAX_BYTES) ?
                             PATTERN_BYTES : hpm_pkg::PAT_MAX_BYTES;
  localparam int CNT_W = $clog2(TEXT_BYTES + 2);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(TEXT_BYTES);

  // ---------------------------------------------------------------- config registers
  logic [3:0][63:0] pat_word_r;
  logic [5:0]       pat_len_r;
  logic             ignore_case_r;
  logic             invert_r;
  logic [2:0]       cfg_idx;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_word_r    <= '0;
      pat_len_r     <= '0;
      ignore_case_r <= 1'b0;
      invert_r      <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hpm_pkg::REG_PATTERN_LENGTH: pat_len_r     <= cfg_pwdata[5:0];
        hpm_pkg::REG_IGNORE_CASE:    ignore_case_r <= cfg_pwdata[0];
        hpm_pkg::REG_INVERT_RESULT:  invert_r      <= cfg_pwdata[0];
        default: begin
          // the four pattern words share the low indexes
          if (cfg_idx <= hpm_pkg::REG_PATTERN_WORD_3) pat_word_r[cfg_idx[1:0]] <= cfg_pwdata;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hpm_pkg::REG_PATTERN_LENGTH: cfg_prdata = {58'd0, pat_len_r};
      hpm_pkg::REG_IGNORE_CASE:    cfg_prdata = {63'd0, ignore_case_r};
      hpm_pkg::REG_INVERT_RESULT:  cfg_prdata = {63'd0, invert_r};
      default: begin
        if (cfg_idx <= hpm_pkg::REG_PATTERN_WORD_3) cfg_prdata = pat_word_r[cfg_idx[1:0]];
        else cfg_prdata = '0;
      end
    endcase
  end

  // pattern bytes, byte 0 from the low end of word 0
  logic [255:0]              pat_flat;
  logic [NUM_CELLS-1:0][7:0] pat_bytes;
  logic                      len_ok;
  hpm_pkg::cls_t             cls;

  assign pat_flat  = pat_word_r;
  assign pat_bytes = pat_flat[(NUM_CELLS*8)-1:0];
  assign len_ok    = (pat_len_r != 6'd0) && (int'(pat_len_r) <= NUM_CELLS);

  hpm_classify #(.NUM_CELLS(NUM_CELLS)) u_classify (
    .pat_bytes (pat_bytes),
    .len       (pat_len_r),
    .len_ok    (len_ok),
    .cls       (cls)
  );

  // ---------------------------------------------------------------- input side
  logic             out_valid_r;
  logic [7:0]       out_data_r;
  logic             in_xfer;
  logic             last_xfer;
  logic [7:0]       text_fold;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             first_byte;

  // the output register frees up in the same cycle it is taken
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign last_xfer = in_xfer && in_tlast;
  assign text_fold = hpm_pkg::fold_byte(in_tdata, ignore_case_r);

  // byte count saturates one past the text limit
  assign first_byte = (cnt_r == '0);
  assign cnt_nxt    = (cnt_r <= CNT_LIMIT) ? cnt_r + 1'b1 : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_xfer) begin
      cnt_r <= in_tlast ? '0 : cnt_nxt;
    end
  end

  // ---------------------------------------------------------------- cell row
  hpm_pkg::chain_t cell_prev [NUM_CELLS];
  hpm_pkg::chain_t cell_nxt  [NUM_CELLS];
  hpm_pkg::chain_t cell_q    [NUM_CELLS];

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    if (g == 0) begin : g_head
      // any byte can start a substring; only the first byte starts the exact run
      assign cell_prev[g] = '{a: 1'b1, d: 1'b0, x: first_byte};
    end else if (g == 1) begin : g_second
      // subdomain suffix starts at pattern byte 1, the dot
      assign cell_prev[g] = '{a: cell_q[g-1].a, d: 1'b1, x: cell_q[g-1].x};
    end else begin : g_body
      assign cell_prev[g] = cell_q[g-1];
    end

    hpm_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .step        (in_xfer),
      .clear       (in_tlast),
      .ignore_case (ignore_case_r),
      .text_byte   (text_fold),
      .pat_byte    (pat_bytes[g]),
      .prev        (cell_prev[g]),
      .flags_nxt   (cell_nxt[g]),
      .flags_r     (cell_q[g])
    );
  end

  // flags of the cell at the pattern's last byte
  hpm_pkg::chain_t sel_nxt;

  always_comb begin
    sel_nxt = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (pat_len_r == 6'(i + 1)) sel_nxt = cell_nxt[i];
    end
  end

  // sticky substring hit for the current name
  logic found_r;
  logic found_nxt;

  assign found_nxt = found_r | (len_ok & sel_nxt.a);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (in_xfer) begin
      found_r <= in_tlast ? 1'b0 : found_nxt;
    end
  end

  // ---------------------------------------------------------------- result
  logic too_long;
  logic raw_match;

  assign too_long = (cnt_nxt > CNT_LIMIT);

  always_comb begin
    case (cls)
      hpm_pkg::CLS_EXACT:     raw_match = sel_nxt.x;
      hpm_pkg::CLS_SUBDOMAIN: raw_match = sel_nxt.d;
      hpm_pkg::CLS_CONTAINS:  raw_match = found_nxt;
      default:                raw_match = 1'b0;
    endcase
    if (too_long) raw_match = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload register, loaded on the final byte
  always_ff @(posedge clk) begin
    if (last_xfer) begin
      out_data_r <= {4'd0, cls, too_long, raw_match ^ invert_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------- checks
  `HPM_ASSERT_NEXT(a_result_loaded, last_xfer, out_valid_r, "final byte gave no result")
  `HPM_ASSERT_NEXT(a_name_cleared, last_xfer, (cnt_r == '0) && !found_r, "name state not cleared")
  `HPM_ASSERT_NOW(a_count_bound, 1'b1, cnt_r <= CNT_LIMIT + 1'b1, "byte count past saturation")
  `HPM_ASSERT_NEXT(a_no_spurious, in_xfer && !in_tlast && !out_valid_r, !out_valid_r, "result without final byte")

endmodule
